// ===== hdl/vps_pkg.sv =====
// Shared types and constants of the vibration pulse sequencer.
// Used by vps_cfg_regs, vps_step and vibration_pulse_sequencer; no dependencies.

package vps_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned OnW       = 8;
  localparam int unsigned ThrW      = 16;
  localparam int unsigned CountW    = 3;
  localparam int unsigned PatW      = 3;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned InDataW   = 56;
  localparam int unsigned OutDataW  = 8;

  // pattern codes
  localparam logic [PatW-1:0] PAT_NONE    = 3'd0;
  localparam logic [PatW-1:0] PAT_SOFT    = 3'd1;
  localparam logic [PatW-1:0] PAT_CONFIRM = 3'd2;
  localparam logic [PatW-1:0] PAT_ALARM   = 3'd3;
  localparam logic [PatW-1:0] PAT_GOAL    = 3'd4;

  // popup event codes
  localparam logic [1:0] EVT_ALARM = 2'd1;
  localparam logic [1:0] EVT_GOAL  = 2'd2;

  // command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_PULSE = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_ON_TIME       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_OFF_TIME      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ALARM_ON_TIME = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CONFIRM_THR   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_GOAL_WINDOW   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ALARM_COUNT   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_GOAL_COUNT    = 3'd6;

  // configuration reset values
  localparam logic [OnW-1:0]    RST_ON_TIME       = 8'd20;
  localparam logic [OnW-1:0]    RST_OFF_TIME      = 8'd60;
  localparam logic [OnW-1:0]    RST_ALARM_ON_TIME = 8'd70;
  localparam logic [ThrW-1:0]   RST_CONFIRM_THR   = 16'd28;
  localparam logic [ThrW-1:0]   RST_GOAL_WINDOW   = 16'd40;
  localparam logic [CountW-1:0] RST_ALARM_COUNT   = 3'd6;
  localparam logic [CountW-1:0] RST_GOAL_COUNT    = 3'd3;

  localparam logic [CountW-1:0] SOFT_PULSES     = 3'd1;
  localparam logic [CountW-1:0] CONFIRM_PULSES  = 3'd2;
  localparam logic [TimeW-1:0]  ALARM_WINDOW_MS = 32'd80;

  typedef struct packed {
    logic [OnW-1:0]    on_time_ms;
    logic [OnW-1:0]    off_time_ms;
    logic [OnW-1:0]    alarm_on_time_ms;
    logic [ThrW-1:0]   confirm_threshold_ms;
    logic [ThrW-1:0]   goal_window_ms;
    logic [CountW-1:0] alarm_pulse_count;
    logic [CountW-1:0] goal_pulse_count;
  } cfg_t;

  typedef struct packed {
    logic             command;
    logic [TimeW-1:0] now_ms;
    logic             enabled;
    logic [1:0]       popup_event;
    logic [ThrW-1:0]  pulse_len_ms;
  } item_t;

  typedef struct packed {
    logic            motor_on;
    logic [PatW-1:0] active_pattern;
  } result_t;

endpackage

// ===== hdl/vps_cfg_regs.sv =====
// Configuration register file of the vibration pulse sequencer.
// Depends on vps_pkg for register indexes, reset values and cfg_t.

module vps_cfg_regs
  import vps_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [CfgIdxW-1:0]  wr_index,
  input  logic [CfgDataW-1:0] wr_data,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_ON_TIME:       cfg_nxt.on_time_ms           = wr_data[OnW-1:0];
        REG_OFF_TIME:      cfg_nxt.off_time_ms          = wr_data[OnW-1:0];
        REG_ALARM_ON_TIME: cfg_nxt.alarm_on_time_ms     = wr_data[OnW-1:0];
        REG_CONFIRM_THR:   cfg_nxt.confirm_threshold_ms = wr_data[ThrW-1:0];
        REG_GOAL_WINDOW:   cfg_nxt.goal_window_ms       = wr_data[ThrW-1:0];
        REG_ALARM_COUNT:   cfg_nxt.alarm_pulse_count    = wr_data[CountW-1:0];
        REG_GOAL_COUNT:    cfg_nxt.goal_pulse_count     = wr_data[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_time_ms           <= RST_ON_TIME;
      cfg_r.off_time_ms          <= RST_OFF_TIME;
      cfg_r.alarm_on_time_ms     <= RST_ALARM_ON_TIME;
      cfg_r.confirm_threshold_ms <= RST_CONFIRM_THR;
      cfg_r.goal_window_ms       <= RST_GOAL_WINDOW;
      cfg_r.alarm_pulse_count    <= RST_ALARM_COUNT;
      cfg_r.goal_pulse_count     <= RST_GOAL_COUNT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/vps_step.sv =====
// Sequencer state registers and the combinational next-state logic for one item.
// Depends on vps_pkg for cfg_t, item_t, result_t and the pattern codes.

module vps_step
  import vps_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic [TimeW-1:0]  cut_r, cut_nxt;
  logic [TimeW-1:0]  ntt_r, ntt_nxt;
  logic [CountW-1:0] left_r, left_nxt;
  logic              drv_r, drv_nxt;
  logic [PatW-1:0]   pat_r, pat_nxt;

  logic [TimeW-1:0]  now;
  logic [TimeW-1:0]  on_sum, off_sum, alarm_on_sum, alarm_cut, goal_cut, dur_cut;
  logic [CountW-1:0] alarm_cnt, goal_cnt;
  logic              start_alarm, start_goal, hit;

  assign now          = item.now_ms;
  assign on_sum       = now + TimeW'(cfg.on_time_ms);
  assign off_sum      = now + TimeW'(cfg.off_time_ms);
  assign alarm_on_sum = now + TimeW'(cfg.alarm_on_time_ms);
  assign alarm_cut    = now + ALARM_WINDOW_MS;
  assign goal_cut     = now + TimeW'(cfg.goal_window_ms);
  assign dur_cut      = now + TimeW'(item.pulse_len_ms);
  assign alarm_cnt    = (cfg.alarm_pulse_count == '0) ? CountW'(1) : cfg.alarm_pulse_count;
  assign goal_cnt     = (cfg.goal_pulse_count == '0) ? CountW'(1) : cfg.goal_pulse_count;

  assign start_alarm = (item.popup_event == EVT_ALARM) && (pat_r != PAT_ALARM) &&
                       (left_r == '0);
  assign start_goal  = !start_alarm && (item.popup_event == EVT_GOAL) &&
                       (pat_r == PAT_NONE);

  always_comb begin
    cut_nxt  = cut_r;
    ntt_nxt  = ntt_r;
    left_nxt = left_r;
    drv_nxt  = drv_r;
    pat_nxt  = pat_r;
    hit      = 1'b0;
    if (item.command == CMD_PULSE) begin
      pat_nxt  = (item.pulse_len_ms >= cfg.confirm_threshold_ms) ? PAT_CONFIRM : PAT_SOFT;
      left_nxt = (item.pulse_len_ms >= cfg.confirm_threshold_ms) ? CONFIRM_PULSES
                                                                 : SOFT_PULSES;
      drv_nxt  = 1'b1;
      ntt_nxt  = on_sum;
      cut_nxt  = dur_cut;
    end else if (!item.enabled) begin
      cut_nxt  = '0;
      ntt_nxt  = '0;
      left_nxt = '0;
      drv_nxt  = 1'b0;
      pat_nxt  = PAT_NONE;
    end else begin
      if (start_alarm) begin
        pat_nxt  = PAT_ALARM;
        drv_nxt  = 1'b1;
        ntt_nxt  = on_sum;
        left_nxt = alarm_cnt;
        cut_nxt  = alarm_cut;
      end else if (start_goal) begin
        pat_nxt  = PAT_GOAL;
        drv_nxt  = 1'b1;
        ntt_nxt  = on_sum;
        left_nxt = goal_cnt;
        cut_nxt  = goal_cut;
      end
      if (left_nxt != '0) begin
        hit = (now >= ntt_nxt);
        if (drv_nxt && hit) begin
          drv_nxt  = 1'b0;
          left_nxt = left_nxt - CountW'(1);
          if (left_nxt == '0) begin
            pat_nxt = PAT_NONE;
            cut_nxt = '0;
          end else begin
            ntt_nxt = off_sum;
          end
        end else if (!drv_nxt && hit) begin
          drv_nxt = 1'b1;
          ntt_nxt = (pat_nxt == PAT_ALARM) ? alarm_on_sum : on_sum;
        end
        // cut the train at its deadline; an alarm always runs to the end
        if ((cut_nxt != '0) && (now >= cut_nxt) && (pat_nxt != PAT_ALARM)) begin
          drv_nxt  = 1'b0;
          left_nxt = '0;
          pat_nxt  = PAT_NONE;
          cut_nxt  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cut_r  <= '0;
      ntt_r  <= '0;
      left_r <= '0;
      drv_r  <= 1'b0;
      pat_r  <= PAT_NONE;
    end else if (step_en) begin
      cut_r  <= cut_nxt;
      ntt_r  <= ntt_nxt;
      left_r <= left_nxt;
      drv_r  <= drv_nxt;
      pat_r  <= pat_nxt;
    end
  end

  assign res.motor_on       = drv_nxt;
  assign res.active_pattern = pat_nxt;

endmodule

// ===== hdl/vibration_pulse_sequencer.sv =====
// Top level of the vibration pulse sequencer: input register, result register, handshakes.
// Depends on vps_pkg, vps_cfg_regs and vps_step.
//
//  channel  | direction | signals                          | payload
//  ---------+-----------+----------------------------------+-------------------------------
//  in_      | slave     | in_tvalid/in_tready/in_tdata/    | tuser: command; tdata: now_ms,
//           |           | in_tuser                         | enabled, popup_event, duration
//  out_     | master    | out_tvalid/out_tready/out_tdata  | motor_on, active_pattern
//  cfg_     | slave     | cfg_valid/cfg_ready/cfg_index/   | register index, write data
//           |           | cfg_data                         |
//
// An item is taken into the input register, and when the result register is free or being
// drained its result is written there together with the new sequencer state; one item per
// cycle is sustained while out_tready is high, and out_tvalid comes from the result register.
// rst_n is synchronous: it empties both registers and restores state and configuration.
// A stalled out_tready holds the result; the input register still takes one more item.

module vibration_pulse_sequencer
  import vps_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // [31:0] now_ms, [32] enabled,
                                          // [34:33] popup_event, [50:35] pulse_len_ms
  input  logic                in_tuser,   // [0] command
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // [0] motor_on, [3:1] active_pattern
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   item_r, item_nxt;
  logic    item_vld_r;
  result_t res, res_r;
  logic    out_vld_r;
  logic    fire;

  assign cfg_ready = 1'b1;

  vps_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // advance the held item when the result register is free or being drained
  assign fire      = item_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !item_vld_r || fire;

  assign item_nxt.command      = in_tuser;
  assign item_nxt.now_ms       = in_tdata[31:0];
  assign item_nxt.enabled      = in_tdata[32];
  assign item_nxt.popup_event  = in_tdata[34:33];
  assign item_nxt.pulse_len_ms = in_tdata[50:35];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_nxt;
    end
  end

  vps_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (fire),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0, res_r.active_pattern, res_r.motor_on};

endmodule

// ===== tb/sv/vps_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for vibration_pulse_sequencer: watches the in_, out_ and cfg_ channels,
// predicts motor level and pattern per transaction and compares them in order.
// Depends on vps_pkg for field widths, pattern codes and register indexes.

module vps_checker
  import vps_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                in_tuser,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  mismatches,
  output int                  backlog,
  output int                  checked
);

  localparam int ReportCap = 200;

  cfg_t              settings;
  logic [TimeW-1:0]  cutoff_at;
  logic [TimeW-1:0]  toggle_at;
  logic [CountW-1:0] pulses;
  logic              drive;
  logic [PatW-1:0]   pattern;

  result_t motor_forecast[$];

  function automatic logic [CountW-1:0] train_length(input logic [CountW-1:0] count);
    return (count == 0) ? 3'd1 : count;
  endfunction

  task clear_sequencer();
    cutoff_at = '0;
    toggle_at = '0;
    pulses    = '0;
    drive     = 1'b0;
    pattern   = PAT_NONE;
  endtask

  task launch_train(input logic [PatW-1:0] pat, input logic [TimeW-1:0] now);
    pattern   = pat;
    drive     = 1'b1;
    toggle_at = now + settings.on_time_ms;
    case (pat)
      PAT_SOFT:    pulses = SOFT_PULSES;
      PAT_CONFIRM: pulses = CONFIRM_PULSES;
      PAT_ALARM: begin
        pulses    = train_length(settings.alarm_pulse_count);
        cutoff_at = now + ALARM_WINDOW_MS;
      end
      default: begin
        pulses    = train_length(settings.goal_pulse_count);
        cutoff_at = now + settings.goal_window_ms;
      end
    endcase
  endtask

  task advance_sequencer(input item_t it, output result_t level);
    if (it.command == CMD_PULSE) begin
      launch_train((it.pulse_len_ms >= settings.confirm_threshold_ms) ? PAT_CONFIRM : PAT_SOFT,
                   it.now_ms);
      cutoff_at = it.now_ms + it.pulse_len_ms;
    end else if (!it.enabled) begin
      clear_sequencer();
    end else begin
      if (it.popup_event == EVT_ALARM && pattern != PAT_ALARM && pulses == 0) begin
        launch_train(PAT_ALARM, it.now_ms);
      end else if (it.popup_event == EVT_GOAL && pattern == PAT_NONE) begin
        launch_train(PAT_GOAL, it.now_ms);
      end
      // an idle sequencer neither toggles nor applies the cutoff
      if (pulses != 0) begin
        if (drive && it.now_ms >= toggle_at) begin
          drive  = 1'b0;
          pulses = pulses - 1'b1;
          if (pulses == 0) begin
            pattern   = PAT_NONE;
            cutoff_at = '0;
          end else begin
            toggle_at = it.now_ms + settings.off_time_ms;
          end
        end else if (!drive && it.now_ms >= toggle_at) begin
          drive     = 1'b1;
          toggle_at = it.now_ms + ((pattern == PAT_ALARM) ? settings.alarm_on_time_ms
                                                          : settings.on_time_ms);
        end
        // alarm trains ignore the deadline; the toggle time is kept
        if (cutoff_at != 0 && it.now_ms >= cutoff_at && pattern != PAT_ALARM) begin
          drive     = 1'b0;
          pulses    = '0;
          pattern   = PAT_NONE;
          cutoff_at = '0;
        end
      end
    end
    level.motor_on       = drive;
    level.active_pattern = pattern;
  endtask

  always @(posedge clk) begin : watch
    item_t   it;
    result_t seen;
    result_t want;
    if (!rst_n) begin
      settings.on_time_ms           = RST_ON_TIME;
      settings.off_time_ms          = RST_OFF_TIME;
      settings.alarm_on_time_ms     = RST_ALARM_ON_TIME;
      settings.confirm_threshold_ms = RST_CONFIRM_THR;
      settings.goal_window_ms       = RST_GOAL_WINDOW;
      settings.alarm_pulse_count    = RST_ALARM_COUNT;
      settings.goal_pulse_count     = RST_GOAL_COUNT;
      clear_sequencer();
      motor_forecast.delete();
      mismatches = 0;
      backlog    = 0;
      checked    = 0;
    end else begin
      // compare before predicting so a fresh transaction never matches this edge's result
      if (out_tvalid && out_tready) begin
        seen.motor_on       = out_tdata[0];
        seen.active_pattern = out_tdata[3:1];
        checked++;
        if (motor_forecast.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportCap)
            $display("%0t: unexpected result, expected none, got motor_on=%0d pattern=%0d",
                     $time, seen.motor_on, seen.active_pattern);
        end else begin
          want = motor_forecast.pop_front();
          if (seen.motor_on !== want.motor_on ||
              seen.active_pattern !== want.active_pattern) begin
            mismatches++;
            if (mismatches <= ReportCap)
              $display({"%0t: result %0d expected motor_on=%0d pattern=%0d, ",
                        "got motor_on=%0d pattern=%0d"},
                       $time, checked, want.motor_on, want.active_pattern,
                       seen.motor_on, seen.active_pattern);
          end
        end
        if (mismatches == ReportCap + 1)
          $display("%0t: further mismatches are counted only", $time);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ON_TIME:       settings.on_time_ms           = cfg_data[OnW-1:0];
          REG_OFF_TIME:      settings.off_time_ms          = cfg_data[OnW-1:0];
          REG_ALARM_ON_TIME: settings.alarm_on_time_ms     = cfg_data[OnW-1:0];
          REG_CONFIRM_THR:   settings.confirm_threshold_ms = cfg_data[ThrW-1:0];
          REG_GOAL_WINDOW:   settings.goal_window_ms       = cfg_data[ThrW-1:0];
          REG_ALARM_COUNT:   settings.alarm_pulse_count    = cfg_data[CountW-1:0];
          REG_GOAL_COUNT:    settings.goal_pulse_count     = cfg_data[CountW-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        it.command      = in_tuser;
        it.now_ms       = in_tdata[31:0];
        it.enabled      = in_tdata[32];
        it.popup_event  = in_tdata[34:33];
        it.pulse_len_ms = in_tdata[50:35];
        advance_sequencer(it, want);
        motor_forecast.push_back(want);
      end
      backlog = motor_forecast.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the vibration_pulse_sequencer testbench: clock, reset, stimulus and verdict.
// Depends on vps_pkg, the vibration_pulse_sequencer RTL and vps_checker.

module testbench;
  import vps_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 120;
  localparam int BlockItems = 108;

  localparam logic [1:0] EVT_NONE  = 2'd0;
  localparam logic [1:0] EVT_OTHER = 2'd3;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                in_tuser   = 1'b0;
  logic                out_tready = 1'b0;
  logic                cfg_valid  = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;
  wire                 in_tready;
  wire                 out_tvalid;
  wire [OutDataW-1:0]  out_tdata;
  wire                 cfg_ready;

  int mismatches;
  int backlog;
  int checked;

  int          tx_idle_pct  = 25;
  int          rx_stall_pct = 74;
  bit          hold_request = 1'b0;
  int          quiet_cycles = 0;
  logic [31:0] clock_ms     = '0;
  logic [15:0] cur_thr      = RST_CONFIRM_THR;
  int          ticks_sent   = 0;
  int          pulses_sent  = 0;
  int          settings_used = 1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  vibration_pulse_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  vps_checker u_scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .backlog    (backlog),
    .checked    (checked)
  );

  // result side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, QuietLimit);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  task send(input logic cmd, input logic [31:0] now, input logic en,
            input logic [1:0] popup, input logic [15:0] dur);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {5'd0, dur, popup, en, now};
    do @(posedge clk); while (!in_tready);
    if (cmd == CMD_PULSE) pulses_sent++;
    else ticks_sent++;
  endtask

  // valid stays high across back-to-back writes; the caller drops it
  task write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task apply_settings(input logic [OnW-1:0] on_ms, input logic [OnW-1:0] off_ms,
                      input logic [OnW-1:0] alarm_on_ms, input logic [ThrW-1:0] thr_ms,
                      input logic [ThrW-1:0] window_ms, input logic [CountW-1:0] alarm_cnt,
                      input logic [CountW-1:0] goal_cnt);
    write_reg(REG_ON_TIME, CfgDataW'(on_ms));
    write_reg(REG_OFF_TIME, CfgDataW'(off_ms));
    write_reg(REG_ALARM_ON_TIME, CfgDataW'(alarm_on_ms));
    write_reg(REG_CONFIRM_THR, thr_ms);
    write_reg(REG_GOAL_WINDOW, window_ms);
    write_reg(REG_ALARM_COUNT, CfgDataW'(alarm_cnt));
    write_reg(REG_GOAL_COUNT, CfgDataW'(goal_cnt));
    cfg_valid <= 1'b0;
    cur_thr = thr_ms;
    settings_used++;
  endtask

  // drop valid, then wait until the scoreboard holds no outstanding result
  task settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task send_random();
    int          kind;
    int          jump;
    int          pick;
    logic [15:0] dur;
    logic [1:0]  popup;
    jump = $urandom_range(99);
    if (jump < 3) clock_ms = $urandom();
    else if (jump < 5) clock_ms = clock_ms - $urandom_range(1, 50);
    else clock_ms = clock_ms + $urandom_range(0, 30);
    case ($urandom_range(4))
      0, 1: dur = 16'($urandom_range(0, 120));
      2: dur = 16'(cur_thr + $urandom_range(0, 4) - 16'd2);
      3: dur = 16'($urandom());
      default: dur = 16'($urandom_range(0, 300));
    endcase
    pick = $urandom_range(99);
    if (pick < 70) popup = EVT_NONE;
    else if (pick < 82) popup = EVT_ALARM;
    else if (pick < 94) popup = EVT_GOAL;
    else popup = EVT_OTHER;
    kind = $urandom_range(99);
    if (kind < 12)
      send(CMD_PULSE, clock_ms, 1'($urandom_range(1)), 2'($urandom_range(3)), dur);
    else
      send(CMD_TICK, clock_ms, kind >= 15, popup, dur);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed pass at reset settings
    send(CMD_TICK, 32'd1000, 1'b1, EVT_NONE, 16'hFFFF);
    send(CMD_TICK, 32'd1000, 1'b1, EVT_ALARM, 16'd0);
    send(CMD_TICK, 32'd1010, 1'b1, EVT_GOAL, 16'd0);
    send(CMD_TICK, 32'd1020, 1'b1, EVT_ALARM, 16'd0);
    send(CMD_TICK, 32'd1080, 1'b1, EVT_OTHER, 16'd0);
    send(CMD_TICK, 32'd1090, 1'b1, EVT_NONE, 16'd0);
    send(CMD_TICK, 32'd1095, 1'b0, EVT_ALARM, 16'd0);
    send(CMD_PULSE, 32'd1100, 1'b0, EVT_OTHER, 16'd27);
    send(CMD_TICK, 32'd1120, 1'b1, EVT_NONE, 16'd0);
    send(CMD_PULSE, 32'd1130, 1'b1, EVT_NONE, 16'd28);
    send(CMD_TICK, 32'd1150, 1'b1, EVT_GOAL, 16'd0);
    send(CMD_TICK, 32'd1158, 1'b1, EVT_NONE, 16'd0);
    send(CMD_PULSE, 32'd1200, 1'b1, EVT_NONE, 16'd0);
    send(CMD_TICK, 32'd1200, 1'b1, EVT_NONE, 16'd0);
    send(CMD_TICK, 32'd1210, 1'b1, EVT_GOAL, 16'd0);
    send(CMD_TICK, 32'd1230, 1'b1, EVT_NONE, 16'd0);
    send(CMD_TICK, 32'd1250, 1'b1, EVT_NONE, 16'd0);
    // deadline sum wraps to zero, so no cutoff applies
    send(CMD_PULSE, 32'hFFFF_FF9C, 1'b1, EVT_NONE, 16'd100);
    send(CMD_TICK, 32'hFFFF_FFFF, 1'b1, EVT_NONE, 16'd0);
    send(CMD_TICK, 32'd0, 1'b1, EVT_NONE, 16'd0);
    send(CMD_PULSE, 32'd5000, 1'b1, EVT_ALARM, 16'hFFFF);
    send(CMD_TICK, 32'd5020, 1'b1, EVT_ALARM, 16'd0);
    send(CMD_TICK, 32'hFFFF_FFFF, 1'b0, EVT_OTHER, 16'hFFFF);

    for (int blk = 0; blk < 6; blk++) begin
      settle();
      case (blk)
        0: apply_settings(8'd1, 8'd1, 8'd1, 16'd0, 16'd0, 3'd0, 3'd1);
        2: apply_settings(8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 3'd7, 3'd7);
        4: apply_settings(OnW'($urandom_range(1, 40)), OnW'($urandom_range(1, 80)),
                          OnW'($urandom_range(1, 80)), ThrW'($urandom_range(0, 60)),
                          ThrW'($urandom_range(0, 200)), 3'd7, 3'd0);
        5: apply_settings(RST_ON_TIME, RST_OFF_TIME, RST_ALARM_ON_TIME, RST_CONFIRM_THR,
                          RST_GOAL_WINDOW, RST_ALARM_COUNT, RST_GOAL_COUNT);
        default: apply_settings(OnW'($urandom_range(1, 40)), OnW'($urandom_range(1, 80)),
                                OnW'($urandom_range(1, 80)), ThrW'($urandom_range(0, 60)),
                                ThrW'($urandom_range(0, 200)),
                                CountW'($urandom_range(1, 7)),
                                CountW'($urandom_range(1, 7)));
      endcase
      tx_idle_pct  = (blk < 2) ? 25 : (blk < 4) ? 74 : 0;
      rx_stall_pct = (blk < 2) ? 74 : (blk < 4) ? 25 : 0;
      // let one block run across the 32-bit time wrap
      clock_ms = (blk == 1) ? 32'hFFFF_FA00 : $urandom();
      if (blk == 4) hold_request = 1'b1;
      repeat (BlockItems) send_random();
    end
    settle();

    $display("Covered %0d ticks and %0d pulse requests under %0d register settings,",
             ticks_sent, pulses_sent, settings_used);
    $display("three pacing modes, a long result hold-off and time wrap; %0d results checked.",
             checked);
    if (mismatches == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/vps_pkg.sv
hdl/vps_cfg_regs.sv
hdl/vps_step.sv
hdl/vibration_pulse_sequencer.sv
tb/sv/vps_checker.sv
tb/sv/testbench.sv
